// ===== design/sige_pkg.sv =====
// Shared constants and types for the stereo graphic equaliser.
`default_nettype none
package sige_pkg;
    localparam int NumBands   = 10;
    localparam int NumStages  = 2;
    localparam int NumCoefs   = 5;
    localparam int NumHist    = 4;
    localparam int CoefDepth  = NumBands * NumStages * NumCoefs;
    localparam int HistDepth  = NumBands * 2 * NumStages * NumHist;
    localparam int CoefAw     = $clog2(CoefDepth);
    localparam int HistAw     = $clog2(HistDepth);
    localparam int BandW      = (NumBands > 1) ? $clog2(NumBands) : 1;
    localparam int StageW     = (NumStages > 1) ? $clog2(NumStages) : 1;
    localparam int DigitW     = 4;
    localparam int NumDigits  = 32 / DigitW;
    localparam int DigCntW    = $clog2(NumDigits);
    localparam logic [31:0] GainOne = 32'h0800_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_GAIN   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LD,
        ST_MUL,
        ST_ACC,
        ST_Y,
        ST_WB,
        ST_GLD,
        ST_FIN,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== design/sige_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sige_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/stereo_iir_graphic_equalizer.sv =====
// Top level of the ten-band stereo graphic equaliser with a digit-serial multiplier.
// A sample beat runs the left channel through every band, then the right, before its
// result beat is offered; coefficient and gain beats are taken in the idle state.
// Throughput: one item at a time; the 4-bit-per-cycle shared multiplier and the
// single-write, single-read history RAM set it.
// Reset (aresetn low, synchronous): enable set, gains 1.0, history valid bits cleared.
`default_nettype none
module stereo_iir_graphic_equalizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: left_in[15:0], right_in[31:16], band[35:32], stage[38:36],
    //        coef_select[41:39], value[73:42], zero pad[79:74]
    input  wire logic [79:0] s_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: left_out[15:0], right_out[31:16]
    output logic      [31:0] m_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import sige_pkg::*;

    // input field split
    logic signed [15:0] in_left, in_right;
    logic [3:0]         in_band;
    logic [2:0]         in_stage, in_sel;
    logic [31:0]        in_value;
    opcode_t            in_op;
    logic               s_acc;

    assign in_left  = s_tdata[15:0];
    assign in_right = s_tdata[31:16];
    assign in_band  = s_tdata[35:32];
    assign in_stage = s_tdata[38:36];
    assign in_sel   = s_tdata[41:39];
    assign in_value = s_tdata[73:42];
    assign in_op    = opcode_t'(s_tuser);

    // configuration register
    logic enable_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            enable_reg <= pwdata[0];
        end
    end

    // sequencer registers
    state_t              state_reg, state_next;
    logic [BandW-1:0]    band_reg;
    logic [StageW-1:0]   stage_reg;
    logic                ch_reg;
    logic [2:0]          j_reg;
    logic [1:0]          wb_reg;
    logic                gphase_reg;
    logic [DigCntW-1:0]  dig_reg;
    logic signed [31:0]  mcand_reg, mplier_reg;
    logic signed [63:0]  prod_reg, acc_reg, bacc_reg;
    logic signed [31:0]  x_reg, pcm_x_reg, h0_old_reg, h2_old_reg, y_reg;
    logic signed [15:0]  lsave_reg, res_l_reg, res_r_reg, pcm_r_reg;
    logic                out_vld_reg;
    logic [31:0]         out_data_reg;

    // gains: ten registers, reset to unity
    logic [31:0] gain_reg [NumBands];

    // memories
    logic              coef_we;
    logic [CoefAw-1:0] coef_waddr, coef_raddr;
    logic [31:0]       coef_rdata;
    logic              hist_we;
    logic [HistAw-1:0] hist_waddr, hist_raddr;
    logic [31:0]       hist_wdata, hist_rdata;
    logic [HistDepth-1:0] hist_vld_reg;
    logic              hist_rvld_reg;

    assign s_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign coef_we = s_acc && in_op == OP_COEF && 32'(in_band) < NumBands
                     && 32'(in_stage) < NumStages && in_sel <= 3'd4;
    assign coef_waddr = CoefAw'((32'(in_band) * NumStages + 32'(in_stage)) * NumCoefs
                                + 32'(in_sel));
    assign coef_raddr = CoefAw'((32'(band_reg) * NumStages + 32'(stage_reg)) * NumCoefs
                                + 32'(j_reg));

    sige_ram #(.Width(32), .Depth(CoefDepth)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // history row base: band, channel, stage
    logic [HistAw-1:0] hist_base;
    logic [1:0]        wb_slot;
    assign hist_base = HistAw'(((32'(band_reg) * 2 + 32'(ch_reg)) * NumStages
                                + 32'(stage_reg)) * NumHist);
    assign hist_raddr = hist_base + HistAw'(j_reg - 3'd1);

    // write back order: x2<=x1, x1<=x, y2<=y1, y1<=y
    always_comb begin
        unique case (wb_reg)
            2'd0: begin wb_slot = 2'd1; hist_wdata = h0_old_reg; end
            2'd1: begin wb_slot = 2'd0; hist_wdata = x_reg;      end
            2'd2: begin wb_slot = 2'd3; hist_wdata = h2_old_reg; end
            default: begin wb_slot = 2'd2; hist_wdata = y_reg;   end
        endcase
    end
    assign hist_waddr = hist_base + HistAw'(wb_slot);
    assign hist_we    = (state_reg == ST_WB);

    sige_ram #(.Width(32), .Depth(HistDepth)) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // unwritten history reads as zero
    logic signed [31:0] hist_val;
    assign hist_val = hist_rvld_reg ? hist_rdata : 32'sd0;

    // one 4-bit digit of the multiplier a cycle; top digit carries the sign
    logic [DigitW-1:0]       dig_bits;
    logic signed [DigitW:0]  dig_s;
    logic signed [36:0]      pp;
    logic signed [63:0]      prod_step;
    assign dig_bits  = mplier_reg[{dig_reg, 2'b00} +: DigitW];
    assign dig_s     = (dig_reg == DigCntW'(NumDigits - 1)) ? {dig_bits[DigitW-1], dig_bits}
                                                           : {1'b0, dig_bits};
    assign pp        = mcand_reg * dig_s;
    assign prod_step = prod_reg + (64'(pp) <<< {dig_reg, 2'b00});

    // stage output rounding and saturation
    logic signed [63:0] y_round, o_round;
    logic signed [31:0] y_sat;
    logic signed [15:0] o_sat;
    assign y_round = (acc_reg + 64'sd67108864) >>> 27;
    assign o_round = (bacc_reg + 64'sd2147483648) >>> 32;
    always_comb begin
        if (y_round > 64'sd2147483647) begin
            y_sat = 32'sh7fff_ffff;
        end else if (y_round < -64'sd2147483648) begin
            y_sat = 32'sh8000_0000;
        end else begin
            y_sat = y_round[31:0];
        end
        if (o_round > 64'sd32767) begin
            o_sat = 16'sh7fff;
        end else if (o_round < -64'sd32768) begin
            o_sat = 16'sh8000;
        end else begin
            o_sat = o_round[15:0];
        end
    end

    logic out_free;
    assign out_free = !out_vld_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && in_op == OP_SAMPLE) begin
                    state_next = enable_reg ? ST_RD : ST_OUT;
                end
            end
            ST_RD:  state_next = ST_LD;
            ST_LD:  state_next = ST_MUL;
            ST_GLD: state_next = ST_MUL;
            ST_MUL: begin
                if (dig_reg == DigCntW'(NumDigits - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (gphase_reg) begin
                    state_next = (32'(band_reg) == NumBands - 1) ? ST_FIN : ST_RD;
                end else begin
                    state_next = (j_reg == 3'd4) ? ST_Y : ST_RD;
                end
            end
            ST_Y: state_next = ST_WB;
            ST_WB: begin
                if (wb_reg == 2'd3) begin
                    state_next = (32'(stage_reg) == NumStages - 1) ? ST_GLD : ST_RD;
                end
            end
            ST_FIN: state_next = ch_reg ? ST_OUT : ST_RD;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_vld_reg  <= 1'b0;
            hist_vld_reg <= '0;
            for (int b = 0; b < NumBands; b++) begin
                gain_reg[b] <= GainOne;
            end
        end else begin
            state_reg <= state_next;
            if (s_acc && in_op == OP_GAIN && 32'(in_band) < NumBands) begin
                gain_reg[in_band[BandW-1:0]] <= in_value;
            end
            if (hist_we) begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
            if (state_reg == ST_OUT && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        hist_rvld_reg <= hist_vld_reg[hist_raddr];
        unique case (state_reg)
            ST_IDLE: begin
                band_reg   <= '0;
                stage_reg  <= '0;
                ch_reg     <= 1'b0;
                j_reg      <= 3'd0;
                wb_reg     <= 2'd0;
                gphase_reg <= 1'b0;
                acc_reg    <= '0;
                bacc_reg   <= '0;
                x_reg      <= 32'(in_left) <<< 9;
                pcm_x_reg  <= 32'(in_left) <<< 9;
                pcm_r_reg  <= in_right;
                res_l_reg  <= in_left;
                res_r_reg  <= in_right;
            end
            ST_RD: ;
            ST_LD: begin
                mcand_reg  <= (j_reg == 3'd0) ? x_reg : hist_val;
                mplier_reg <= coef_rdata;
                prod_reg   <= '0;
                dig_reg    <= '0;
                if (j_reg == 3'd1) h0_old_reg <= hist_val;
                if (j_reg == 3'd3) h2_old_reg <= hist_val;
            end
            ST_GLD: begin
                mcand_reg  <= y_reg;
                mplier_reg <= gain_reg[band_reg];
                prod_reg   <= '0;
                dig_reg    <= '0;
                gphase_reg <= 1'b1;
            end
            ST_MUL: begin
                prod_reg <= prod_step;
                dig_reg  <= dig_reg + 1'b1;
            end
            ST_ACC: begin
                if (gphase_reg) begin
                    bacc_reg   <= bacc_reg + (prod_reg >>> 4);
                    gphase_reg <= 1'b0;
                    stage_reg  <= '0;
                    j_reg      <= 3'd0;
                    acc_reg    <= '0;
                    x_reg      <= pcm_x_reg;
                    band_reg   <= band_reg + 1'b1;
                end else begin
                    if (j_reg >= 3'd3) begin
                        acc_reg <= acc_reg - (prod_reg >>> 2);
                    end else begin
                        acc_reg <= acc_reg + (prod_reg >>> 2);
                    end
                    if (j_reg != 3'd4) j_reg <= j_reg + 3'd1;
                end
            end
            ST_Y: begin
                y_reg  <= y_sat;
                wb_reg <= 2'd0;
            end
            ST_WB: begin
                wb_reg <= wb_reg + 2'd1;
                if (wb_reg == 2'd3 && 32'(stage_reg) != NumStages - 1) begin
                    stage_reg <= stage_reg + 1'b1;
                    x_reg     <= y_reg;
                    acc_reg   <= '0;
                    j_reg     <= 3'd0;
                end
            end
            ST_FIN: begin
                band_reg  <= '0;
                stage_reg <= '0;
                j_reg     <= 3'd0;
                acc_reg   <= '0;
                bacc_reg  <= '0;
                if (!ch_reg) begin
                    lsave_reg <= o_sat;
                    ch_reg    <= 1'b1;
                    x_reg     <= 32'(pcm_r_reg) <<< 9;
                    pcm_x_reg <= 32'(pcm_r_reg) <<< 9;
                end else begin
                    res_l_reg <= lsave_reg;
                    res_r_reg <= o_sat;
                end
            end
            ST_OUT: begin
                if (out_free) out_data_reg <= {res_r_reg, res_l_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // bypass: a sample beat with the equaliser off goes straight to the result stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op == OP_SAMPLE && !enable_reg) |=> state_reg == ST_OUT)
        else $error("bypass sample did not go to output stage");
    // every product starts from digit zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LD || state_reg == ST_GLD) |=> (dig_reg == '0 && state_reg == ST_MUL))
        else $error("multiplier not restarted");
    // history write back only follows a stage result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && wb_reg == 2'd0) |-> $past(state_reg) == ST_Y)
        else $error("history written without a stage result");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_stereo_iir_graphic_equalizer.sv =====
// Self-checking testbench for the stereo graphic equaliser: stream stimulus, predictor, checker.
`default_nettype none
module tb_stereo_iir_graphic_equalizer;
    timeunit 1ns;
    timeprecision 1ps;
    import sige_pkg::*;

    localparam int SampleCycles = 2604;
    localparam logic [2:0] EnableAddr = 3'd0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stereo_iir_graphic_equalizer dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: coefficients, gains, per band/channel/stage history, enable
    logic signed [31:0] coef_mem [NumBands][NumStages][NumCoefs];
    logic signed [31:0] gain_mem [NumBands];
    logic signed [31:0] hist_mem [NumBands][2][NumStages][NumHist];
    logic               eq_on;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_t;
    stereo_t eq_expected [$];

    int  mismatches = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;
    int  hold_left = 0;

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Advance one channel through all bands and return the weighted, saturated mix
    function automatic logic signed [15:0] equalise(int ch, logic signed [15:0] pcm);
        longint mix;
        longint acc;
        longint r;
        logic signed [31:0] x;
        logic signed [31:0] y;
        mix = 0;
        for (int b = 0; b < NumBands; b++) begin
            x = 32'(pcm) * 512;
            for (int s = 0; s < NumStages; s++) begin
                acc = (longint'(x) * longint'(coef_mem[b][s][0])) >>> 2;
                acc += (longint'(hist_mem[b][ch][s][0]) * longint'(coef_mem[b][s][1])) >>> 2;
                acc += (longint'(hist_mem[b][ch][s][1]) * longint'(coef_mem[b][s][2])) >>> 2;
                acc -= (longint'(hist_mem[b][ch][s][2]) * longint'(coef_mem[b][s][3])) >>> 2;
                acc -= (longint'(hist_mem[b][ch][s][3]) * longint'(coef_mem[b][s][4])) >>> 2;
                y = clip32((acc + (64'sd1 <<< 26)) >>> 27);
                hist_mem[b][ch][s][1] = hist_mem[b][ch][s][0];
                hist_mem[b][ch][s][0] = x;
                hist_mem[b][ch][s][3] = hist_mem[b][ch][s][2];
                hist_mem[b][ch][s][2] = y;
                x = y;
            end
            mix += (longint'(x) * longint'(gain_mem[b])) >>> 4;
        end
        r = (mix + (64'sd1 <<< 31)) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Apply one accepted beat to the predictor
    task automatic predict_beat(opcode_t op, logic signed [15:0] l, logic signed [15:0] r,
                                logic [3:0] band, logic [2:0] stage, logic [2:0] sel,
                                logic signed [31:0] val);
        stereo_t res;
        case (op)
            OP_COEF: begin
                if (band < NumBands && stage < NumStages && sel < NumCoefs)
                    coef_mem[band][stage][sel] = val;
            end
            OP_GAIN: begin
                if (band < NumBands) gain_mem[band] = val;
            end
            OP_SAMPLE: begin
                res.left  = eq_on ? equalise(0, l) : l;
                res.right = eq_on ? equalise(1, r) : r;
                eq_expected.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Offer one beat, after a random gap if the sender idles; hold it until the block takes it
    task automatic send_item(opcode_t op, logic [15:0] l, logic [15:0] r, logic [3:0] band,
                             logic [2:0] stage, logic [2:0] sel, logic [31:0] val);
        int gap;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, val, sel, stage, band, r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(op, l, r, band, stage, sel, val);
    endtask

    task automatic send_sample(logic [15:0] l, logic [15:0] r);
        send_item(OP_SAMPLE, l, r, 4'($urandom), 3'($urandom), 3'($urandom), $urandom);
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain every expected beat, then give a stray write time to settle
    task automatic wait_idle();
        release_input();
        while (eq_expected.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_enable(logic on);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= EnableAddr;
        pwdata  <= {31'b0, on};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eq_on = on;
    endtask

    function automatic logic [31:0] mild_coef();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endfunction

    function automatic logic [31:0] mild_gain();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return $urandom_range(0, 32'h1000_0000);
    endfunction

    // Receiver: check every result beat, draw stalls, honour a long hold-off
    initial begin
        int gap;
        stereo_t want;
        gap = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (eq_expected.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    mismatches++;
                end else begin
                    want = eq_expected.pop_front();
                    if (m_tdata[15:0] !== want.left) begin
                        $error("left_out expected %0d actual %0d",
                               want.left, $signed(m_tdata[15:0]));
                        mismatches++;
                    end
                    if (m_tdata[31:16] !== want.right) begin
                        $error("right_out expected %0d actual %0d",
                               want.right, $signed(m_tdata[31:16]));
                        mismatches++;
                    end
                end
                gap = receiver_idles ? $urandom_range(0, 4) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Load every coefficient so that no sample ever reads an unwritten entry
    task automatic test_coef_load();
        for (int b = 0; b < NumBands; b++)
            for (int s = 0; s < NumStages; s++)
                for (int k = 0; k < NumCoefs; k++)
                    send_item(OP_COEF, '0, '0, 4'(b), 3'(s), 3'(k),
                              (k == 0) ? 32'sh0800_0000 : $signed(mild_coef()) >>> 3);
        wait_idle();
    endtask

    // Field extremes, gain extremes, ignored writes and the unused opcode
    task automatic test_directed();
        send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h0000, 16'hffff);
        send_sample(16'h0001, 16'h0000);
        send_item(OP_GAIN, '0, '0, 4'd0, 3'd0, 3'd0, 32'h7fff_ffff);
        send_item(OP_GAIN, '0, '0, 4'd9, 3'd7, 3'd7, 32'h8000_0000);
        send_sample(16'h7fff, 16'h8000);
        send_item(OP_COEF, '0, '0, 4'd9, 3'd1, 3'd0, 32'h7fff_ffff);
        send_item(OP_COEF, '0, '0, 4'd9, 3'd1, 3'd4, 32'h8000_0000);
        send_sample(16'h8000, 16'h7fff);
        send_item(OP_COEF, 16'hffff, 16'hffff, 4'd15, 3'd0, 3'd0, 32'hffff_ffff);
        send_item(OP_COEF, '0, '0, 4'd10, 3'd7, 3'd0, 32'h1234_5678);
        send_item(OP_COEF, '0, '0, 4'd0, 3'd2, 3'd0, 32'h1234_5678);
        send_item(OP_COEF, '0, '0, 4'd0, 3'd0, 3'd5, 32'h1234_5678);
        send_item(OP_COEF, '0, '0, 4'd0, 3'd0, 3'd7, 32'h1234_5678);
        send_item(OP_GAIN, '0, '0, 4'd15, 3'd0, 3'd0, 32'h0);
        send_item(OP_NONE, 16'hffff, 16'hffff, 4'hf, 3'd7, 3'd7, 32'hffff_ffff);
        send_item(OP_GAIN, '0, '0, 4'd0, 3'd0, 3'd0, GainOne);
        send_item(OP_GAIN, '0, '0, 4'd9, 3'd0, 3'd0, GainOne);
        send_item(OP_COEF, '0, '0, 4'd9, 3'd1, 3'd0, 32'h0400_0000);
        send_item(OP_COEF, '0, '0, 4'd9, 3'd1, 3'd4, 32'h0);
        send_sample(16'h1234, 16'hedcb);
        wait_idle();
    endtask

    // Bypass: samples pass unchanged, history frozen, writes still land
    task automatic test_bypass();
        write_enable(1'b0);
        send_sample(16'h7fff, 16'h8000);
        send_item(OP_GAIN, '0, '0, 4'd3, 3'd0, 3'd0, 32'h0400_0000);
        send_item(OP_COEF, '0, '0, 4'd3, 3'd0, 3'd1, mild_coef());
        for (int i = 0; i < 6; i++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
        write_enable(1'b1);
        send_sample(16'h4000, 16'hc000);
        wait_idle();
    endtask

    // Mostly samples with random filter updates and some noise beats
    task automatic test_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_sample(16'($urandom), 16'($urandom));
            else if (pick < 87)
                send_item(OP_COEF, 16'($urandom), 16'($urandom),
                          ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9)),
                          ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1)),
                          ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)),
                          mild_coef());
            else if (pick < 95)
                send_item(OP_GAIN, 16'($urandom), 16'($urandom),
                          ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9)),
                          3'($urandom), 3'($urandom), mild_gain());
            else
                send_item(OP_NONE, 16'($urandom), 16'($urandom), 4'($urandom), 3'($urandom),
                          3'($urandom), $urandom);
        end
        wait_idle();
    endtask

    // Hold the result side off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_left = 3 * SampleCycles;
        sender_idles = 1'b0;
        for (int i = 0; i < 8; i++) send_sample(16'($urandom), 16'($urandom));
        sender_idles = 1'b1;
        wait_idle();
    endtask

    initial begin
        for (int b = 0; b < NumBands; b++) begin
            gain_mem[b] = GainOne;
            for (int c = 0; c < 2; c++)
                for (int s = 0; s < NumStages; s++)
                    for (int h = 0; h < NumHist; h++) hist_mem[b][c][s][h] = '0;
            for (int s = 0; s < NumStages; s++)
                for (int k = 0; k < NumCoefs; k++) coef_mem[b][s][k] = '0;
        end
        eq_on = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_coef_load();
        test_directed();
        test_bypass();
        test_random(400);
        // quiet stretch: no idling on either side
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(150);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        write_enable(1'b0);
        test_random(120);
        write_enable(1'b1);
        test_backpressure();
        test_random(400);

        repeat (2 * SampleCycles) @(posedge aclk);
        if (mismatches == 0 && eq_expected.size() == 0) begin
            $display("stereo_iir_graphic_equalizer regression: pass");
        end else begin
            $display("stereo_iir_graphic_equalizer regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #300_000_000;
        $display("stereo_iir_graphic_equalizer regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/sige_pkg.sv
design/sige_ram.sv
design/stereo_iir_graphic_equalizer.sv
verif/tb_stereo_iir_graphic_equalizer.sv
